### design/synth_voice_oscillator_envelope_top_macros.svh
// assertion macros used by the voice top module
`ifndef SYNTH_VOICE_OSCILLATOR_ENVELOPE_TOP_MACROS_SVH
`define SYNTH_VOICE_OSCILLATOR_ENVELOPE_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define SVOE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define SVOE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/svoe_pkg.sv
// shared codes and constants of the synth voice
package svoe_pkg;

   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_NOTE_ON  = 2'd1;
   localparam logic [1:0] OP_NOTE_OFF = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   localparam logic [2:0] CSR_WAVE_MODE = 3'd0;
   localparam logic [2:0] CSR_ATTACK    = 3'd1;
   localparam logic [2:0] CSR_DECAY     = 3'd2;
   localparam logic [2:0] CSR_RELEASE   = 3'd3;
   localparam logic [2:0] CSR_SUSTAIN   = 3'd4;
   localparam logic [2:0] CSR_PEAK      = 3'd5;

   localparam logic [2:0] WAVE_SINE     = 3'd0;
   localparam logic [2:0] WAVE_SQUARE   = 3'd1;
   localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
   localparam logic [2:0] WAVE_RAMP     = 3'd3;
   localparam logic [2:0] WAVE_MIX      = 3'd4;

   typedef enum logic [2:0] {
      LVL_ATTACK,
      LVL_DECAY_UP,
      LVL_DECAY_DOWN,
      LVL_SUSTAIN,
      LVL_RELEASE,
      LVL_ZERO
   } level_mode_type;

   localparam logic [2:0]  RST_WAVE_MODE = 3'd4;
   localparam logic [19:0] RST_ATTACK    = 20'd8820;
   localparam logic [19:0] RST_DECAY     = 20'd4410;
   localparam logic [19:0] RST_RELEASE   = 20'd22050;
   localparam logic [15:0] RST_SUSTAIN   = 16'd52428;
   localparam logic [15:0] RST_PEAK      = 16'd65535;

   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [15:0] LEVEL_FLOOR = 16'd6;

endpackage

### design/synth_voice_oscillator_envelope_top.sv
// synth voice: phase accumulator oscillator scaled by a linear adsr envelope
// note-on and note-off items are taken only while idle, leave the sequencer idle and give no result
// a tick goes through the index, wave, multiply, divide, level and sample states, then done
// the divide state runs the one-bit-per-cycle restoring divider of the envelope
// the result register lets the next item enter while a result waits; req_stall holds items off until idle
// reset (synchronous) restores register defaults, idles the envelope, clears phase
`include "synth_voice_oscillator_envelope_top_macros.svh"
module synth_voice_oscillator_envelope_top #(
   parameter int SINE_TABLE_DEPTH = 256,
   parameter int TICK_COUNT_WIDTH = 21
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [31:0]        req_phase_step,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample,
   output logic [15:0]        rsp_envelope_level,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [19:0]        csr_write_data
);

   // widths derived from the parameters
   localparam int IW  = $clog2(SINE_TABLE_DEPTH + 1);        // sine table index
   localparam int TW  = TICK_COUNT_WIDTH;
   localparam int CW  = (TW > 21) ? TW : 21;                  // envelope compare width
   localparam int PW  = CW + 16;                              // dividend width
   localparam int DCW = $clog2(PW + 1);                       // divide step counter

   // sequencer codes
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_IDX  = 3'd1;
   localparam logic [2:0] ST_WAVE = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_LVL  = 3'd5;
   localparam logic [2:0] ST_SMP  = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   // quarter-wave sine entry, worked out at elaboration with a q30 taylor series
   function automatic logic [14:0] sine_entry(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] v;
      longint      acc;
      x    = 64'(svoe_pkg::HALF_PI_Q30) * 64'(k) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      acc  = 0;
      for (int n = 0; n < 7; n++) begin
         if (n % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
         term = (term * x2) >> 30;
         term = term / 64'((2 * n + 2) * (2 * n + 3));
      end
      if (acc < 0) acc = 0;
      v = (64'(acc) * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      return v[14:0];
   endfunction

   logic [14:0] sine_rom [SINE_TABLE_DEPTH + 1];
   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_sine
      assign sine_rom[k] = sine_entry(k);
   end

   // configuration registers
   logic [2:0]  wave_mode_ff;
   logic [19:0] attack_ff, decay_ff, release_ff;
   logic [15:0] sustain_ff, peak_ff;

   // voice state
   logic [31:0]   phase_ff, note_step_ff;
   logic          gate_on_ff;
   logic [TW-1:0] gate_ticks_ff, release_ticks_ff;

   // sequencer and datapath registers
   logic [2:0]                state_ff, state_in;
   logic [31:0]               pcap_ff;          // phase captured for this tick
   logic [IW-1:0]             idx_ff;
   logic signed [16:0]        wave_ff;
   svoe_pkg::level_mode_type  lmode_ff, lmode_in;
   logic [CW-1:0]             ma_ff, ma_in;
   logic [15:0]               mb_ff, mb_in;
   logic [19:0]               den_ff, den_in;
   logic [PW-1:0]             dvd_ff;           // dividend, quotient shifts in
   logic [20:0]               rem_ff;
   logic [DCW-1:0]            cnt_ff;
   logic [15:0]               lvl_ff;
   logic signed [15:0]        smp_ff;
   logic                      rsp_valid_ff;
   logic signed [15:0]        rsp_sample_ff;
   logic [15:0]               rsp_level_ff;

   logic req_take, tick_take, rsp_take, rsp_load;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign tick_take = req_take && (req_op == svoe_pkg::OP_TICK);
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // envelope segment choice, from the counters before they advance
   logic [19:0]   a_eff, d_eff, r_eff;
   logic [CW-1:0] g_ext, r_ext, a_ext, ad_sum;
   always_comb begin
      a_eff  = (attack_ff == 20'd0) ? 20'd1 : attack_ff;
      d_eff  = (decay_ff == 20'd0) ? 20'd1 : decay_ff;
      r_eff  = (release_ff == 20'd0) ? 20'd1 : release_ff;
      g_ext  = CW'(gate_ticks_ff);
      r_ext  = CW'(release_ticks_ff);
      a_ext  = CW'(a_eff);
      ad_sum = CW'({1'b0, a_eff} + {1'b0, d_eff});
      lmode_in = svoe_pkg::LVL_ZERO;
      ma_in    = '0;
      mb_in    = 16'd0;
      den_in   = 20'd1;
      if (gate_on_ff) begin
         if (g_ext <= a_ext) begin
            lmode_in = svoe_pkg::LVL_ATTACK;
            ma_in    = g_ext;
            mb_in    = peak_ff;
            den_in   = a_eff;
         end else if (g_ext <= ad_sum) begin
            ma_in  = g_ext - a_ext;
            den_in = d_eff;
            if (sustain_ff >= peak_ff) begin
               lmode_in = svoe_pkg::LVL_DECAY_UP;
               mb_in    = sustain_ff - peak_ff;
            end else begin
               lmode_in = svoe_pkg::LVL_DECAY_DOWN;
               mb_in    = peak_ff - sustain_ff;
            end
         end else begin
            lmode_in = svoe_pkg::LVL_SUSTAIN;
         end
      end else if (r_ext < CW'(r_eff)) begin
         lmode_in = svoe_pkg::LVL_RELEASE;
         ma_in    = r_ext;
         mb_in    = sustain_ff;
         den_in   = r_eff;
      end
   end

   // sine index: low phase bits scaled by the table depth
   logic [IW+29:0] idx_prod;
   assign idx_prod = (IW + 30)'(pcap_ff[29:0]) * (IW + 30)'(SINE_TABLE_DEPTH);

   // wave shaping
   logic [1:0]         quad;
   logic [IW-1:0]      sidx;
   logic signed [16:0] sine_v, square_v, ramp_v, tri_v, wave_v;
   logic signed [18:0] tri_raw;
   logic signed [17:0] mix_sum;
   always_comb begin
      quad     = pcap_ff[31:30];
      sidx     = quad[0] ? (IW'(SINE_TABLE_DEPTH) - idx_ff) : idx_ff;
      sine_v   = $signed({2'b00, sine_rom[sidx]});
      if (quad[1]) sine_v = -sine_v;
      square_v = (pcap_ff != 32'd0 && !pcap_ff[31]) ? 17'sd16384 : -17'sd16384;
      case (quad)
         2'd0:    tri_raw = $signed({2'b00, pcap_ff[31:15]});
         2'd3:    tri_raw = $signed({2'b00, pcap_ff[31:15]}) - 19'sd131072;
         default: tri_raw = 19'sd65536 - $signed({2'b00, pcap_ff[31:15]});
      endcase
      // exact quarter point saturates
      if (tri_raw > 19'sd32767) tri_raw = 19'sd32767;
      tri_v   = tri_raw[16:0];
      ramp_v  = $signed({1'b0, pcap_ff[31:16]}) - 17'sd32768;
      mix_sum = 18'(tri_v) + 18'(square_v);
      case (wave_mode_ff)
         svoe_pkg::WAVE_SINE:     wave_v = sine_v;
         svoe_pkg::WAVE_SQUARE:   wave_v = square_v;
         svoe_pkg::WAVE_TRIANGLE: wave_v = tri_v;
         svoe_pkg::WAVE_RAMP:     wave_v = ramp_v;
         svoe_pkg::WAVE_MIX:      wave_v = 17'(mix_sum >>> 1);
         default:                 wave_v = 17'sd0;
      endcase
   end

   // the shared multiplier: envelope numerator, then wave times level
   logic signed [CW:0]    mul_x;
   logic signed [16:0]    mul_y;
   logic signed [CW+17:0] mul_p;
   always_comb begin
      if (state_ff == ST_SMP) begin
         mul_x = (CW + 1)'(wave_ff);
         mul_y = $signed({1'b0, lvl_ff});
      end else begin
         mul_x = $signed({1'b0, ma_ff});
         mul_y = $signed({1'b0, mb_ff});
      end
      mul_p = (CW + 18)'(mul_x) * (CW + 18)'(mul_y);
   end

   // one restoring divide step
   logic [20:0] rem_sh;
   logic        qbit;
   always_comb begin
      rem_sh = {rem_ff[19:0], dvd_ff[PW-1]};
      qbit   = (rem_sh >= {1'b0, den_ff});
   end

   // level from the quotient, small levels read as silence
   logic [15:0] q16, lvl_v;
   always_comb begin
      q16 = dvd_ff[15:0];
      case (lmode_ff)
         svoe_pkg::LVL_ATTACK:     lvl_v = q16;
         svoe_pkg::LVL_DECAY_UP:   lvl_v = peak_ff + q16;
         svoe_pkg::LVL_DECAY_DOWN: lvl_v = peak_ff - q16;
         svoe_pkg::LVL_SUSTAIN:    lvl_v = sustain_ff;
         svoe_pkg::LVL_RELEASE:    lvl_v = sustain_ff - q16;
         default:                  lvl_v = 16'd0;
      endcase
      if (lvl_v <= svoe_pkg::LEVEL_FLOOR) lvl_v = 16'd0;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (tick_take) state_in = ST_IDX;
         ST_IDX:  state_in = ST_WAVE;
         ST_WAVE: state_in = ST_MUL;
         ST_MUL:  state_in = ST_DIV;
         ST_DIV:  if (cnt_ff == DCW'(1)) state_in = ST_LVL;
         ST_LVL:  state_in = ST_SMP;
         ST_SMP:  state_in = ST_DONE;
         ST_DONE: if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         wave_mode_ff     <= svoe_pkg::RST_WAVE_MODE;
         attack_ff        <= svoe_pkg::RST_ATTACK;
         decay_ff         <= svoe_pkg::RST_DECAY;
         release_ff       <= svoe_pkg::RST_RELEASE;
         sustain_ff       <= svoe_pkg::RST_SUSTAIN;
         peak_ff          <= svoe_pkg::RST_PEAK;
         phase_ff         <= 32'd0;
         note_step_ff     <= 32'd0;
         gate_on_ff       <= 1'b0;
         gate_ticks_ff    <= '0;
         release_ticks_ff <= '1;
      end else begin
         state_ff <= state_in;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_take) rsp_valid_ff <= 1'b0;

         if (csr_write_enable) begin
            case (csr_index)
               svoe_pkg::CSR_WAVE_MODE: wave_mode_ff <= csr_write_data[2:0];
               svoe_pkg::CSR_ATTACK:    attack_ff    <= csr_write_data;
               svoe_pkg::CSR_DECAY:     decay_ff     <= csr_write_data;
               svoe_pkg::CSR_RELEASE:   release_ff   <= csr_write_data;
               svoe_pkg::CSR_SUSTAIN:   sustain_ff   <= csr_write_data[15:0];
               svoe_pkg::CSR_PEAK:      peak_ff      <= csr_write_data[15:0];
               default: ;
            endcase
         end

         if (req_take) begin
            case (req_op)
               svoe_pkg::OP_NOTE_ON: begin
                  note_step_ff  <= req_phase_step;
                  gate_ticks_ff <= '0;
                  gate_on_ff    <= 1'b1;
               end
               svoe_pkg::OP_NOTE_OFF: begin
                  release_ticks_ff <= '0;
                  gate_on_ff       <= 1'b0;
               end
               svoe_pkg::OP_TICK: begin
                  // sample uses the values before the advance
                  phase_ff <= phase_ff + note_step_ff;
                  if (gate_ticks_ff != '1) gate_ticks_ff <= gate_ticks_ff + 1'b1;
                  if (release_ticks_ff != '1) release_ticks_ff <= release_ticks_ff + 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (tick_take) begin
         pcap_ff  <= phase_ff;
         lmode_ff <= lmode_in;
         ma_ff    <= ma_in;
         mb_ff    <= mb_in;
         den_ff   <= den_in;
      end
      case (state_ff)
         ST_IDX:  idx_ff  <= idx_prod[IW+29:30];
         ST_WAVE: wave_ff <= wave_v;
         ST_MUL: begin
            dvd_ff <= mul_p[PW-1:0];
            rem_ff <= 21'd0;
            cnt_ff <= DCW'(PW);
         end
         ST_DIV: begin
            rem_ff <= qbit ? (rem_sh - {1'b0, den_ff}) : rem_sh;
            dvd_ff <= {dvd_ff[PW-2:0], qbit};
            cnt_ff <= cnt_ff - 1'b1;
         end
         ST_LVL:  lvl_ff <= lvl_v;
         ST_SMP:  smp_ff <= mul_p[31:16];
         default: ;
      endcase
      if (rsp_load) begin
         rsp_sample_ff <= smp_ff;
         rsp_level_ff  <= lvl_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample         = rsp_sample_ff;
   assign rsp_envelope_level = rsp_level_ff;

   `SVOE_ASSERT_NEXT(a_tick_starts, tick_take, state_ff == ST_IDX, "tick did not start sequence")
   `SVOE_ASSERT_NEXT(a_note_quick, req_take && !tick_take, state_ff == ST_IDLE, "note item busied block")
   `SVOE_ASSERT_NEXT(a_done_delivers, rsp_load, rsp_valid && state_ff == ST_IDLE, "result not posted")
   `SVOE_ASSERT_NOW(a_div_count, state_ff == ST_DIV, cnt_ff != '0, "divide counter ran out")

endmodule
